>>> rtl/b64d_pkg.sv
// Shared types, codes and the character classifier for the base64 stream decoder.
// No dependencies; used by every module under rtl/.
package b64d_pkg;

   // Classifier codes above the 6-bit value range
   localparam logic [6:0] SYM_SKIP = 7'd64;
   localparam logic [6:0] SYM_PAD  = 7'd65;
   localparam logic [6:0] SYM_BAD  = 7'd66;

   localparam logic [6:0] SYM_VALUE_LIMIT = 7'd64;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

   localparam logic [7:0] OFFSET_LOWER = 8'd26;
   localparam logic [7:0] OFFSET_DIGIT = 8'd52;

   // Register map
   localparam logic REG_OUTPUT_CAPACITY = 1'b0;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_INVALID  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_INVALID  = 2'd2,
      ERR_OVERFLOW = 2'd3
   } err_type;

   // One queued job: up to three bytes and an optional status word
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      nbytes;
      logic            has_status;
      result_kind_type status_kind;
      logic [15:0]     total;
   } job_type;

   function automatic logic [6:0] classify(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'd0;
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - CHAR_UPPER_A;
            classify = v[6:0];
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - CHAR_LOWER_A + OFFSET_LOWER;
            classify = v[6:0];
         end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = c - CHAR_DIGIT_0 + OFFSET_DIGIT;
            classify = v[6:0];
         end else if (c == CHAR_PLUS) begin
            classify = 7'd62;
         end else if (c == CHAR_SLASH) begin
            classify = 7'd63;
         end else if (c == CHAR_NEWLINE) begin
            classify = SYM_SKIP;
         end else if (c == CHAR_EQUALS) begin
            classify = SYM_PAD;
         end else begin
            classify = SYM_BAD;
         end
      end
   endfunction

endpackage

>>> rtl/b64d_front.sv
// Front end: classifies characters, assembles sextets, checks capacity, builds jobs.
// Depends on b64d_pkg.
module b64d_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           char_code,
   input  logic                 end_of_message,
   input  logic [15:0]          capacity,
   output logic                 push,
   output b64d_pkg::job_type    job
);

   localparam int WIDE = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 2;

   logic [17:0]           buf_ff, buf_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] bc_ff, bc_in;
   logic                  pad_ff, pad_in;
   b64d_pkg::err_type     err_ff, err_in;

   logic [6:0]            sym;
   logic                  live, is_val, is_bad, is_pad, grp, tail, over, emit;
   logic [23:0]           full;
   logic [17:0]           buf_mid;
   logic [1:0]            cnt_mid, k;
   b64d_pkg::err_type     err_mid, err_new;
   logic [WIDE-1:0]       cap_w, cmax_w, limit_w, sum_w, bc_new_w;

   always_comb begin
      sym    = b64d_pkg::classify(char_code);
      live   = (err_ff == b64d_pkg::ERR_NONE) && !pad_ff;
      is_val = live && (sym < b64d_pkg::SYM_VALUE_LIMIT);
      is_bad = live && (sym == b64d_pkg::SYM_BAD);
      is_pad = live && (sym == b64d_pkg::SYM_PAD);
      full   = {buf_ff, sym[5:0]};
      grp    = is_val && (cnt_ff == 2'd3);

      if (grp) begin
         buf_mid = 18'd0;
         cnt_mid = 2'd0;
      end else if (is_val) begin
         buf_mid = {buf_ff[11:0], sym[5:0]};
         cnt_mid = cnt_ff + 2'd1;
      end else begin
         buf_mid = buf_ff;
         cnt_mid = cnt_ff;
      end

      err_mid = is_bad ? b64d_pkg::ERR_INVALID : err_ff;
      tail    = end_of_message && (err_mid == b64d_pkg::ERR_NONE)
                && ((cnt_mid == 2'd3) || (cnt_mid == 2'd2));

      if (grp) begin
         k = 2'd3;
      end else if (tail) begin
         k = (cnt_mid == 2'd3) ? 2'd2 : 2'd1;
      end else begin
         k = 2'd0;
      end

      // Limit is the capacity register capped at the counter's range
      cap_w    = WIDE'(capacity);
      cmax_w   = (WIDE'(1) << COUNT_BITS) - WIDE'(1);
      limit_w  = (cap_w < cmax_w) ? cap_w : cmax_w;
      sum_w    = WIDE'(bc_ff) + WIDE'(k);
      over     = (k != 2'd0) && (sum_w > limit_w);
      emit     = (k != 2'd0) && !over;
      err_new  = over ? b64d_pkg::ERR_OVERFLOW : err_mid;
      bc_new_w = emit ? sum_w : WIDE'(bc_ff);

      job.data = '0;
      if (grp) begin
         job.data[0] = full[23:16];
         job.data[1] = full[15:8];
         job.data[2] = full[7:0];
      end else if (cnt_mid == 2'd3) begin
         job.data[0] = buf_mid[17:10];
         job.data[1] = buf_mid[9:2];
      end else begin
         job.data[0] = buf_mid[11:4];
      end
      job.nbytes      = emit ? k : 2'd0;
      job.has_status  = end_of_message;
      job.status_kind = (err_new == b64d_pkg::ERR_NONE) ? b64d_pkg::KIND_DONE
                        : b64d_pkg::result_kind_type'(err_new);
      job.total       = bc_new_w[15:0];

      push = accept && (emit || end_of_message);

      buf_in = buf_ff;
      cnt_in = cnt_ff;
      bc_in  = bc_ff;
      pad_in = pad_ff;
      err_in = err_ff;
      if (accept) begin
         if (end_of_message) begin
            // clear for the next message
            buf_in = 18'd0;
            cnt_in = 2'd0;
            bc_in  = '0;
            pad_in = 1'b0;
            err_in = b64d_pkg::ERR_NONE;
         end else begin
            buf_in = buf_mid;
            cnt_in = cnt_mid;
            bc_in  = bc_new_w[COUNT_BITS-1:0];
            pad_in = pad_ff | is_pad;
            err_in = err_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= 18'd0;
         cnt_ff <= 2'd0;
         bc_ff  <= '0;
         pad_ff <= 1'b0;
         err_ff <= b64d_pkg::ERR_NONE;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         bc_ff  <= bc_in;
         pad_ff <= pad_in;
         err_ff <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_eom: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_message) |=> (cnt_ff == 2'd0 && bc_ff == '0 && !pad_ff
                                      && err_ff == b64d_pkg::ERR_NONE))
      else $error("message state not cleared after last character");
   a_no_bytes_after_error: assert property (@(posedge clock) disable iff (reset)
      (err_ff != b64d_pkg::ERR_NONE) |-> (job.nbytes == 2'd0))
      else $error("bytes emitted after an error");
`endif

endmodule

>>> rtl/b64d_fifo.sv
// Job queue between the decoder front end and the result sequencer.
// Depends on b64d_pkg.
module b64d_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::job_type job_in,
   input  logic              pop,
   output b64d_pkg::job_type job_out,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   b64d_pkg::job_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      full    = (cnt_ff == DEPTH_CNT);
      empty   = (cnt_ff == '0);
      job_out = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full job queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty job queue");
`endif

endmodule

>>> rtl/b64d_back.sv
// Result sequencer: walks each queued job and drives the registered result channel.
// Depends on b64d_pkg.
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  b64d_pkg::job_type job,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic [1:0]        rsp_result_kind,
   output logic [15:0]       rsp_total_length,
   output logic              rsp_last_of_run
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] total_ff, total_in;
   logic        last_ff, last_in;
   logic        load, take, is_last;
   logic [2:0]  n_total;

   always_comb begin
      n_total = {1'b0, job.nbytes} + {2'b00, job.has_status};
      is_last = ({1'b0, idx_ff} + 3'd1) == n_total;
      load    = !valid_ff || rsp_ready;
      take    = load && !empty;
      pop     = take && is_last;

      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = !empty;
      end
      if (take) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end

      if (idx_ff < job.nbytes) begin
         case (idx_ff)
            2'd0:    byte_in = job.data[0];
            2'd1:    byte_in = job.data[1];
            2'd2:    byte_in = job.data[2];
            default: byte_in = 8'd0;
         endcase
         kind_in  = b64d_pkg::KIND_DATA;
         total_in = 16'd0;
      end else begin
         byte_in  = 8'd0;
         kind_in  = job.status_kind;
         total_in = job.total;
      end
      last_in = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Payload holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff  <= byte_in;
         kind_ff  <= kind_in;
         total_ff <= total_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_total_length = total_ff;
   assign rsp_last_of_run  = last_ff;

`ifndef SYNTHESIS
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != b64d_pkg::KIND_DATA) |-> rsp_last_of_run)
      else $error("status word not marked last of run");
   a_data_no_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == b64d_pkg::KIND_DATA) |-> (rsp_total_length == 16'd0))
      else $error("data word carries a length");
`endif

endmodule

>>> rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: register port, front end, job queue, sequencer.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
// Usage:
//   Request channel (req_*): one encoded character per word, req_end_of_message
//   on the final character of a message. Result channel (rsp_*): one decoded
//   byte per word (kind 0), then a status word at message end (kind 1 done,
//   2 invalid character, 3 capacity overflow) with the byte count.
//   rsp_last_of_run marks the last word caused by one character.
//   Register 0 at byte address 0 is output_capacity (16 bits, reset 65535).
// Timing:
//   A character is taken every cycle while the job queue has room. Its job
//   enters the job queue, and its first word is then registered at the output.
//   The sequencer drives one word per cycle while the receiver is ready; a
//   character causes zero to four words (three bytes plus the status), and no
//   message causes more words than it has characters.
// Reset and stall:
//   Reset clears message state, empties the queue, drops rsp_valid and restores
//   the capacity. A stalled receiver holds the output word, jobs gather in the
//   QUEUE_DEPTH-entry queue, and req_ready drops when it is full.
module base64_stream_decoder #(
   parameter int COUNT_BITS  = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_message,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_total_length,
   output logic        rsp_last_of_run,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]       cap_ff, cap_in;
   logic              req_accept, push, pop, q_full, q_empty, csr_write;
   b64d_pkg::job_type job_in, job_out;

   // Register port: no wait states, word index in paddr[2]
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == b64d_pkg::REG_OUTPUT_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == b64d_pkg::REG_OUTPUT_CAPACITY)
                       ? {16'd0, cap_ff} : 32'd0;

   always_comb begin
      cap_in = cap_ff;
      if (csr_write) begin
         cap_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= b64d_pkg::CAPACITY_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Take a character whenever the queue has room for its job
   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   b64d_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .char_code      (req_char_code),
      .end_of_message (req_end_of_message),
      .capacity       (cap_ff),
      .push           (push),
      .job            (job_in)
   );

   b64d_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (job_in),
      .pop     (pop),
      .job_out (job_out),
      .full    (q_full),
      .empty   (q_empty)
   );

   b64d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (job_out),
      .empty            (q_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_total_length (rsp_total_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
